@@ hdl/sat_pkg.sv @@
package sat_pkg;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_ADD2  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_PRESENT = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_RANGE   = 3'd3;
    localparam logic [2:0] ST_POS     = 3'd4;

    localparam logic [1:0] RS_OK      = 2'd0;
    localparam logic [1:0] RS_PRESENT = 2'd1;
    localparam logic [1:0] RS_FULL    = 2'd2;
    localparam logic [1:0] RS_NONE    = 2'd3;

    localparam logic [8:0] NODE_COUNT_RST = 9'd256;

    typedef struct packed {
        logic load;
        logic clr;
        logic n_lat;
        logic probe;
        logic step;
        logic eq_rd;
        logic q_res;
        logic res_present;
        logic res_full;
        logic sh_init;
        logic sh_rd;
        logic sh_wr;
        logic ins_wr;
        logic swap;
        logic pos_rd;
        logic pos_bad;
        logic elem_lat;
        logic out_load;
    } sat_cmd_t;

    typedef struct packed {
        logic       in_range;
        logic [1:0] op;
        logic       lo_lt_hi;
        logic       found;
        logic       full;
        logic       sh_more;
        logic       pos_ok;
        logic       dual_go;
        logic       clr_last;
        logic       out_free;
    } sat_stat_t;

endpackage

@@ hdl/sorted_adjacency_table.sv @@
// Sorted adjacency table: per node a sorted, duplicate-free neighbour row.
// Input channel s_*: one transaction is one operation (add one way, add both
// ways, neighbour query, read row element). Output channel m_*: exactly one
// result transaction per input transaction, in order.
// Configuration: cfg_wen/cfg_wdata write node_count; write only when idle.
// An out-of-range node gets its result without touching the rows. A query
// binary-searches the row. An add searches, moves the larger entries up one
// place and inserts the neighbour; a both-ways add whose forward insert is
// done and whose neighbour is in range then inserts the node into the
// neighbour's row, which can also be rejected as present or full.
// One transaction at a time: s_tready rises at the same edge that registers
// the result and raises m_tvalid.
// After reset the row counts are cleared node by node, during which
// s_tready stays low; node_count returns to 256.
// If the receiver stalls, the block holds the finished result and does not
// accept the next transaction until the output register can be loaded.
module sorted_adjacency_table #(
    parameter int NODES      = 256,
    parameter int MAX_DEGREE = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // operation[1:0], node[9:2], neighbor[17:10], position[22:18]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[2:0], reverse_status[4:3], is_neighbor[5],
                                   // element[13:6], row_size[19:14], total_entries[33:20]
    input  logic        cfg_wen,
    input  logic [8:0]  cfg_wdata  // node_count
);
    import sat_pkg::*;

    sat_cmd_t  cmd;
    sat_stat_t stat;

    sat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sat_dpath #(
        .NODES      (NODES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

@@ hdl/sat_ctrl.sv @@
module sat_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  sat_pkg::sat_stat_t stat,
    output sat_pkg::sat_cmd_t  cmd
);
    import sat_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CNT   = 4'd2;
    localparam logic [3:0] S_NLAT  = 4'd3;
    localparam logic [3:0] S_SRCH  = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_EQW   = 4'd6;
    localparam logic [3:0] S_SHIFT = 4'd7;
    localparam logic [3:0] S_SHW   = 4'd8;
    localparam logic [3:0] S_RDCHK = 4'd9;
    localparam logic [3:0] S_RDW   = 4'd10;
    localparam logic [3:0] S_SWAP  = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.in_range ? S_CNT : S_FIN;
                end
            end
            S_CNT:
            begin
                state_next = S_NLAT;
            end
            S_NLAT:
            begin
                cmd.n_lat  = 1'b1;
                state_next = (stat.op == OP_READ) ? S_RDCHK : S_SRCH;
            end
            S_SRCH:
            begin
                if (stat.lo_lt_hi)
                begin
                    cmd.probe  = 1'b1;
                    state_next = S_CMP;
                end
                else
                begin
                    cmd.eq_rd  = 1'b1;
                    state_next = S_EQW;
                end
            end
            S_CMP:
            begin
                cmd.step   = 1'b1;
                state_next = S_SRCH;
            end
            S_EQW:
            begin
                if (stat.op == OP_QUERY)
                begin
                    cmd.q_res  = 1'b1;
                    state_next = S_FIN;
                end
                else if (stat.found)
                begin
                    cmd.res_present = 1'b1;
                    state_next      = S_FIN;
                end
                else if (stat.full)
                begin
                    cmd.res_full = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.sh_init = 1'b1;
                    state_next  = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (stat.sh_more)
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = S_SHW;
                end
                else
                begin
                    cmd.ins_wr = 1'b1;
                    state_next = stat.dual_go ? S_SWAP : S_FIN;
                end
            end
            S_SHW:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = S_SHIFT;
            end
            S_RDCHK:
            begin
                if (stat.pos_ok)
                begin
                    cmd.pos_rd = 1'b1;
                    state_next = S_RDW;
                end
                else
                begin
                    cmd.pos_bad = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_RDW:
            begin
                cmd.elem_lat = 1'b1;
                state_next   = S_FIN;
            end
            S_SWAP:
            begin
                cmd.swap   = 1'b1;
                state_next = S_CNT;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

@@ hdl/sat_dpath.sv @@
module sat_dpath #(
    parameter int NODES      = 256,
    parameter int MAX_DEGREE = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [23:0]        s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata,
    input  logic               cfg_wen,
    input  logic [8:0]         cfg_wdata,
    input  sat_pkg::sat_cmd_t  cmd,
    output sat_pkg::sat_stat_t stat
);
    import sat_pkg::*;

    localparam int NW = $clog2(NODES);
    localparam int IW = $clog2(MAX_DEGREE + 1);
    localparam int AW = $clog2(NODES * MAX_DEGREE);
    localparam int DEPTH = NODES * MAX_DEGREE;

    logic [7:0]    store_mem [DEPTH];
    logic [IW-1:0] cnt_mem [NODES];
    logic [7:0]    store_q;
    logic [IW-1:0] count_q;

    logic [8:0]    node_count_reg;
    logic [NW-1:0] clr_idx_reg;
    logic          m_tvalid_reg;

    logic [1:0]    op_reg;
    logic [7:0]    node_reg;
    logic [7:0]    nb_reg;
    logic [4:0]    pos_reg;
    logic [NW-1:0] row_reg;
    logic [7:0]    key_reg;
    logic          rev_reg;
    logic [IW-1:0] n_reg;
    logic [IW-1:0] lo_reg;
    logic [IW-1:0] hi_reg;
    logic [IW-1:0] sh_reg;
    logic [2:0]    status_reg;
    logic [1:0]    rstat_reg;
    logic          isn_reg;
    logic [7:0]    elem_reg;
    logic [IW-1:0] rsz_reg;
    logic [13:0]   total_reg;
    logic [39:0]   out_reg;

    logic [7:0]    in_node;
    logic [IW-1:0] mid;
    logic [IW-1:0] rd_idx;
    logic [IW-1:0] wr_idx;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] row_base;
    logic          st_we;
    logic [7:0]    st_wdata;
    logic          found;
    logic [2:0]    fwd_code;
    logic [1:0]    rev_code;

    assign in_node  = s_tdata[9:2];
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign row_base = AW'(row_reg) * AW'(MAX_DEGREE);
    assign found    = (lo_reg < n_reg) && (store_q == key_reg);

    always_comb
    begin
        rd_idx = mid;
        if (cmd.eq_rd)
        begin
            rd_idx = lo_reg;
        end
        else if (cmd.sh_rd)
        begin
            rd_idx = sh_reg - IW'(1);
        end
        else if (cmd.pos_rd)
        begin
            rd_idx = IW'(pos_reg);
        end
    end

    assign wr_idx   = cmd.sh_wr ? sh_reg : lo_reg;
    assign st_wdata = cmd.sh_wr ? store_q : key_reg;
    assign st_we    = cmd.sh_wr | cmd.ins_wr;
    assign rd_addr  = row_base + AW'(rd_idx);
    assign wr_addr  = row_base + AW'(wr_idx);

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[wr_addr] <= st_wdata;
        end
        store_q <= store_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            cnt_mem[clr_idx_reg] <= '0;
        end
        else if (cmd.ins_wr)
        begin
            cnt_mem[row_reg] <= n_reg + IW'(1);
        end
        count_q <= cnt_mem[row_reg];
    end

    assign stat.in_range = (32'(in_node) < 32'(node_count_reg)) && (32'(in_node) < NODES);
    assign stat.op       = op_reg;
    assign stat.lo_lt_hi = lo_reg < hi_reg;
    assign stat.found    = found;
    assign stat.full     = 32'(n_reg) >= MAX_DEGREE;
    assign stat.sh_more  = sh_reg > lo_reg;
    assign stat.pos_ok   = 32'(pos_reg) < 32'(n_reg);
    assign stat.dual_go  = (op_reg == OP_ADD2) && !rev_reg &&
                           (32'(nb_reg) < 32'(node_count_reg)) && (32'(nb_reg) < NODES);
    assign stat.clr_last = clr_idx_reg == NW'(NODES - 1);
    assign stat.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
            clr_idx_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            total_reg      <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (cmd.clr)
            begin
                clr_idx_reg <= clr_idx_reg + NW'(1);
            end
            if (cmd.ins_wr)
            begin
                total_reg <= total_reg + 14'd1;
            end
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign fwd_code = cmd.res_present ? ST_PRESENT : (cmd.res_full ? ST_FULL : ST_OK);
    assign rev_code = cmd.res_present ? RS_PRESENT : (cmd.res_full ? RS_FULL : RS_OK);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= s_tdata[1:0];
            node_reg   <= in_node;
            nb_reg     <= s_tdata[17:10];
            pos_reg    <= s_tdata[22:18];
            row_reg    <= NW'(in_node);
            key_reg    <= s_tdata[17:10];
            rev_reg    <= 1'b0;
            status_reg <= stat.in_range ? ST_OK : ST_RANGE;
            rstat_reg  <= RS_NONE;
            isn_reg    <= 1'b0;
            elem_reg   <= '0;
            rsz_reg    <= '0;
        end
        if (cmd.swap)
        begin
            row_reg <= NW'(nb_reg);
            key_reg <= node_reg;
            rev_reg <= 1'b1;
        end
        if (cmd.n_lat)
        begin
            n_reg  <= count_q;
            lo_reg <= '0;
            hi_reg <= count_q;
            if (!rev_reg)
            begin
                rsz_reg <= count_q;
            end
        end
        if (cmd.step)
        begin
            if (store_q < key_reg)
            begin
                lo_reg <= mid + IW'(1);
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        if (cmd.q_res)
        begin
            isn_reg <= found;
        end
        if (cmd.res_present || cmd.res_full || cmd.ins_wr)
        begin
            if (rev_reg)
            begin
                rstat_reg <= rev_code;
            end
            else
            begin
                status_reg <= fwd_code;
            end
        end
        if (cmd.ins_wr && !rev_reg)
        begin
            rsz_reg <= n_reg + IW'(1);
        end
        if (cmd.sh_init)
        begin
            sh_reg <= n_reg;
        end
        if (cmd.sh_wr)
        begin
            sh_reg <= sh_reg - IW'(1);
        end
        if (cmd.pos_bad)
        begin
            status_reg <= ST_POS;
        end
        if (cmd.elem_lat)
        begin
            elem_reg <= store_q;
        end
        if (cmd.out_load)
        begin
            out_reg <= {6'd0, total_reg, 6'(rsz_reg), elem_reg, isn_reg, rstat_reg, status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

endmodule
